/* rtl/core/playfair_digraph_encrypt_unit_assert.svh */
// ----------------------------------------------------------------------------
// Playfair digraph encrypt unit: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge outside reset.
`define PFE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pfe: assertion failed");

// Check prop at every rising edge, reset included.
`define PFE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pfe: assertion failed");

`else

`define PFE_ASSERT(label, clk, rst_n, prop)
`define PFE_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/core/pfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph encrypt package
// Shared widths, register codes, stage payload types and helper functions.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int SIDE   = 5;
  localparam int CELLS  = SIDE * SIDE;
  localparam int CODE_W = 5;
  localparam int POS_W  = 3;
  localparam int IDX_W  = 5;
  localparam int REG_W  = 60;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0]  LOW_RST  = 60'd785332173373971628;
  localparam logic [REG_W-1:0]  MID_RST  = 60'd58057736905188086;
  localparam logic [CODE_W-1:0] LAST_RST = 5'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW  = 2'd0,
    REG_MID  = 2'd1,
    REG_LAST = 2'd2
  } reg_idx_t;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CELLS-1:0][CODE_W-1:0] square_t;
  typedef logic [CELLS-1:0] hit_t;

  typedef struct packed {
    hit_t hit_a;
    hit_t hit_b;
  } match_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } loc_one_t;

  typedef struct packed {
    loc_one_t a;
    loc_one_t b;
  } loc_t;

  typedef struct packed {
    logic             missing;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
  } pick_t;

  typedef struct packed {
    code_t cipher_first;
    code_t cipher_second;
    logic  letter_missing;
  } res_t;

  // Highest matching cell: highest row with a hit, then highest column in it.
  function automatic loc_one_t locate(input hit_t hit);
    logic [SIDE-1:0] row_hit;
    logic [SIDE-1:0] cols;
    loc_one_t        res;
    res  = '0;
    cols = '0;
    for (int r = 0; r < SIDE; r++) begin
      row_hit[r] = |hit[r*SIDE +: SIDE];
    end
    for (int r = 0; r < SIDE; r++) begin
      if (row_hit[r]) begin
        res.row = POS_W'(r);
        cols    = hit[r*SIDE +: SIDE];
      end
    end
    for (int c = 0; c < SIDE; c++) begin
      if (cols[c]) begin
        res.col = POS_W'(c);
      end
    end
    res.found = |row_hit;
    return res;
  endfunction

  function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] x);
    return (x == POS_W'(SIDE - 1)) ? '0 : x + POS_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] cell_index(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
    return IDX_W'(row) * IDX_W'(SIDE) + IDX_W'(col);
  endfunction

endpackage

/* rtl/core/pfe_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair input channel
// Valid/ready channel carrying one plaintext digraph per transfer.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  logic          valid;
  logic          ready;
  pfe_pkg::code_t plain_first;
  pfe_pkg::code_t plain_second;

  modport source (output valid, output plain_first, output plain_second, input ready);
  modport sink   (input valid, input plain_first, input plain_second, output ready);
endinterface

/* rtl/core/pfe_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair result channel
// Valid/ready channel carrying one ciphertext digraph per transfer.
// ----------------------------------------------------------------------------
interface pfe_out_if;
  logic           valid;
  logic           ready;
  pfe_pkg::code_t cipher_first;
  pfe_pkg::code_t cipher_second;
  logic           letter_missing;

  modport source (output valid, output cipher_first, output cipher_second,
                  output letter_missing, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second,
                  input letter_missing, output ready);
endinterface

/* rtl/core/pfe_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair stage 1: cell compare
// Compares both letters against all 25 key square cells.
// ----------------------------------------------------------------------------
module pfe_match (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  output logic             in_rdy,
  input  pfe_pkg::code_t   in_first,
  input  pfe_pkg::code_t   in_second,
  input  pfe_pkg::square_t sq,
  output logic             out_vld,
  input  logic             out_rdy,
  output pfe_pkg::match_t  out_data
);

  logic            vld_r;
  pfe_pkg::match_t data_r;
  pfe_pkg::match_t data_nxt;

  always_comb begin
    for (int i = 0; i < pfe_pkg::CELLS; i++) begin
      data_nxt.hit_a[i] = (sq[i] == in_first);
      data_nxt.hit_b[i] = (sq[i] == in_second);
    end
  end

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/core/pfe_locate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair stage 2: position encode
// Turns each hit vector into row, column and found flag.
// ----------------------------------------------------------------------------
module pfe_locate (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  output logic            in_rdy,
  input  pfe_pkg::match_t in_data,
  output logic            out_vld,
  input  logic            out_rdy,
  output pfe_pkg::loc_t   out_data
);

  logic          vld_r;
  pfe_pkg::loc_t data_r;
  pfe_pkg::loc_t data_nxt;

  always_comb begin
    data_nxt.a = pfe_pkg::locate(in_data.hit_a);
    data_nxt.b = pfe_pkg::locate(in_data.hit_b);
  end

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/core/pfe_rule.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair stage 3: rule apply
// Picks the same-row, same-column or rectangle rule and forms cell indexes.
// ----------------------------------------------------------------------------
module pfe_rule (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  output logic          in_rdy,
  input  pfe_pkg::loc_t in_data,
  output logic          out_vld,
  input  logic          out_rdy,
  output pfe_pkg::pick_t out_data
);

  logic           vld_r;
  pfe_pkg::pick_t data_r;
  pfe_pkg::pick_t data_nxt;

  always_comb begin
    data_nxt.missing = !(in_data.a.found && in_data.b.found);
    if (in_data.a.row == in_data.b.row) begin
      // same row, identical letters included: step right
      data_nxt.idx_a = pfe_pkg::cell_index(in_data.a.row, pfe_pkg::wrap_inc(in_data.a.col));
      data_nxt.idx_b = pfe_pkg::cell_index(in_data.b.row, pfe_pkg::wrap_inc(in_data.b.col));
    end else if (in_data.a.col == in_data.b.col) begin
      data_nxt.idx_a = pfe_pkg::cell_index(pfe_pkg::wrap_inc(in_data.a.row), in_data.a.col);
      data_nxt.idx_b = pfe_pkg::cell_index(pfe_pkg::wrap_inc(in_data.b.row), in_data.b.col);
    end else begin
      data_nxt.idx_a = pfe_pkg::cell_index(in_data.a.row, in_data.b.col);
      data_nxt.idx_b = pfe_pkg::cell_index(in_data.b.row, in_data.a.col);
    end
  end

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/core/pfe_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair stage 4: letter select
// Reads the cipher letters out of the key square into the output register.
// ----------------------------------------------------------------------------
module pfe_select (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  output logic             in_rdy,
  input  pfe_pkg::pick_t   in_data,
  input  pfe_pkg::square_t sq,
  output logic             out_vld,
  input  logic             out_rdy,
  output pfe_pkg::res_t    out_data
);

  logic          vld_r;
  pfe_pkg::res_t data_r;
  pfe_pkg::res_t data_nxt;

  always_comb begin
    data_nxt.letter_missing = in_data.missing;
    // force zero letters when either one was not found
    data_nxt.cipher_first  = in_data.missing ? '0 : sq[in_data.idx_a];
    data_nxt.cipher_second = in_data.missing ? '0 : sq[in_data.idx_b];
  end

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/core/playfair_digraph_encrypt_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph encrypt unit
// Encrypts one letter pair per transfer against a programmable 5x5 key square.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready sink, one plaintext pair (A=0 .. Z=25) per transfer.
//   out_ch : valid/ready source, the cipher pair plus letter_missing, which is
//            set (with both letters zero) when either letter is not in the square.
//   cfg_*  : write port for the key square; index 0 holds cells 0-11, index 1
//            cells 12-23, index 2 cell 24, five bits per cell, row-major.
//            Write it only while no pair is in flight.
// A pair goes from input transfer to valid result through four
// register stages: compare, position encode, rule apply, letter select.
// Throughput is one pair per cycle while out_ch.ready is high; every stage
// takes a new pair when it is empty or its contents move on in the same cycle.
// Reset clears all stage valid bits and loads the default square
// MFHIK / UNOPQ / ZVWXY / ELARG / DSTBC.
// When the receiver stalls, results hold in place, the pipeline fills up and
// in_ch.ready drops once all four stages are full; nothing is dropped.
// ----------------------------------------------------------------------------
`include "playfair_digraph_encrypt_unit_assert.svh"

module playfair_digraph_encrypt_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfe_pkg::REG_W-1:0]           cfg_wdata,
  pfe_in_if.sink                              in_ch,
  pfe_out_if.source                           out_ch
);

  logic [pfe_pkg::REG_W-1:0] low_r;
  logic [pfe_pkg::REG_W-1:0] mid_r;
  pfe_pkg::code_t            last_r;
  pfe_pkg::square_t          sq;

  logic            s1_vld, s1_rdy;
  logic            s2_vld, s2_rdy;
  logic            s3_vld, s3_rdy;
  pfe_pkg::match_t s1_data;
  pfe_pkg::loc_t   s2_data;
  pfe_pkg::pick_t  s3_data;
  pfe_pkg::res_t   s4_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= pfe_pkg::LOW_RST;
      mid_r  <= pfe_pkg::MID_RST;
      last_r <= pfe_pkg::LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfe_pkg::REG_LOW:  low_r  <= cfg_wdata;
        pfe_pkg::REG_MID:  mid_r  <= cfg_wdata;
        pfe_pkg::REG_LAST: last_r <= cfg_wdata[pfe_pkg::CODE_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  assign sq = {last_r, mid_r, low_r};

  pfe_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_ch.valid),
    .in_rdy    (in_ch.ready),
    .in_first  (in_ch.plain_first),
    .in_second (in_ch.plain_second),
    .sq        (sq),
    .out_vld   (s1_vld),
    .out_rdy   (s1_rdy),
    .out_data  (s1_data)
  );

  pfe_locate u_locate (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s1_vld),
    .in_rdy   (s1_rdy),
    .in_data  (s1_data),
    .out_vld  (s2_vld),
    .out_rdy  (s2_rdy),
    .out_data (s2_data)
  );

  pfe_rule u_rule (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s2_vld),
    .in_rdy   (s2_rdy),
    .in_data  (s2_data),
    .out_vld  (s3_vld),
    .out_rdy  (s3_rdy),
    .out_data (s3_data)
  );

  pfe_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld),
    .in_rdy   (s3_rdy),
    .in_data  (s3_data),
    .sq       (sq),
    .out_vld  (out_ch.valid),
    .out_rdy  (out_ch.ready),
    .out_data (s4_data)
  );

  assign out_ch.cipher_first   = s4_data.cipher_first;
  assign out_ch.cipher_second  = s4_data.cipher_second;
  assign out_ch.letter_missing = s4_data.letter_missing;

  `PFE_ASSERT(a_missing_zero, clk, rst_n, out_ch.valid && out_ch.letter_missing |-> (out_ch.cipher_first == 5'd0) && (out_ch.cipher_second == 5'd0))
  `PFE_ASSERT(a_ready_flows, clk, rst_n, out_ch.ready |-> in_ch.ready)
  `PFE_ASSERT(a_stall_fills, clk, rst_n, !in_ch.ready |-> out_ch.valid && s3_vld && s2_vld && s1_vld)
  `PFE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_ch.valid && !s1_vld)

endmodule
